// ----- src/bftl_pkg.sv -----
`default_nettype none

package bftl_pkg;

	localparam int GLYPH_COUNT_DEF = 256;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CODE_SPACE   = 8'h20;
	localparam logic [7:0] CODE_NEWLINE = 8'h0A;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_ADVANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_ADVANCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_READY    = 2'd2;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 72;
	localparam int M_TUSER_W = 2;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_NOT_READY,
		OP_SPACE,
		OP_NEWLINE,
		OP_GLYPH
	} bftl_op_t;

	typedef struct packed {
		bftl_op_t    op;
		logic [7:0]  code;
		logic [7:0]  width;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic        first;
		logic        last;
	} bftl_item_t;

endpackage

`default_nettype wire

// ----- src/bitmap_font_text_layout_top.sv -----
`default_nettype none

// Proportional bitmap font text layout. Load items fill the glyph width table,
// text items walk the pen across the string and produce one result each; every
// input item gives exactly one result. The block sustains one item per clock
// while the output is not stalled: the front stage reads the width table (a
// single-port memory with registered read) in the cycle an item is accepted, a
// two-entry queue follows, and the back stage updates the pen and measures with
// saturating adds. A result passes the front stage register, a queue slot and
// the output register. Table entries hold no reset value and must be loaded
// before text uses them. The user must make configuration writes only while no
// item is in flight; the block itself does not enforce it.
module bitmap_font_text_layout_top #(
	parameter int GLYPH_COUNT = bftl_pkg::GLYPH_COUNT_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// char_code[7:0], glyph_width[15:8], origin_x[31:16], origin_y[47:32],
	// first[48], zero fill[55:49]
	input  wire logic [bftl_pkg::S_TDATA_W-1:0]        s_tdata,
	// kind[0]
	input  wire logic                                  s_tuser,
	input  wire logic                                  s_tlast,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// glyph_code[7:0], pen_x[23:8], pen_y[39:24], text_width[55:40],
	// text_height[71:56]
	output logic [bftl_pkg::M_TDATA_W-1:0]             m_tdata,
	// draw[0], not_ready[1]
	output logic [bftl_pkg::M_TUSER_W-1:0]             m_tuser,
	output logic                                       m_tlast,
	input  wire logic                                  cfg_we,
	input  wire logic [bftl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [bftl_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import bftl_pkg::*;

	logic [7:0]  space_advance_q;
	logic [7:0]  line_advance_q;
	logic        font_ready_q;
	logic        push_valid, push_ready, pop_valid, pop_ready;
	bftl_item_t  push_item, pop_item;
	logic        draw, done_res, not_ready;
	logic [7:0]  glyph_code;
	logic [15:0] pen_x, pen_y, text_width, text_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_advance_q <= '0;
			line_advance_q  <= '0;
			font_ready_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPACE_ADVANCE: space_advance_q <= cfg_wdata[7:0];
				CFG_LINE_ADVANCE:  line_advance_q  <= cfg_wdata[7:0];
				CFG_FONT_READY:    font_ready_q    <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	bftl_front #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.kind       (s_tuser),
		.char_code  (s_tdata[7:0]),
		.glyph_width(s_tdata[15:8]),
		.origin_x   (s_tdata[31:16]),
		.origin_y   (s_tdata[47:32]),
		.first      (s_tdata[48]),
		.last       (s_tlast),
		.font_ready (font_ready_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	bftl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	bftl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.space_advance(space_advance_q),
		.line_advance (line_advance_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.draw         (draw),
		.glyph_code   (glyph_code),
		.pen_x        (pen_x),
		.pen_y        (pen_y),
		.text_width   (text_width),
		.text_height  (text_height),
		.done_res     (done_res),
		.not_ready    (not_ready)
	);

	assign m_tdata = {text_height, text_width, pen_y, pen_x, glyph_code};
	assign m_tuser = {not_ready, draw};
	assign m_tlast = done_res;

	// A refused text item carries nothing but its flag.
	a_not_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0] && !m_tlast)
		else $error("not-ready result carries data");

	// Measures are only reported on the last character of a string.
	a_measures_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[71:40] == '0)
		else $error("measures reported before the end of a string");

	// A glyph is only placed while the font is marked ready.
	a_draw_needs_font: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> font_ready_q)
		else $error("glyph placed while font not ready");

endmodule

`default_nettype wire

// ----- src/bftl_front.sv -----
`default_nettype none

module bftl_front #(
	parameter int GLYPH_COUNT = bftl_pkg::GLYPH_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic [7:0]         char_code,
	input  wire logic [7:0]         glyph_width,
	input  wire logic [15:0]        origin_x,
	input  wire logic [15:0]        origin_y,
	input  wire logic               first,
	input  wire logic               last,
	input  wire logic               font_ready,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output bftl_pkg::bftl_item_t    push_item
);
	import bftl_pkg::*;

	localparam int ADDR_W = $clog2(GLYPH_COUNT);

	logic [7:0]  width_mem [GLYPH_COUNT];
	logic        valid_s1;
	logic        kind_s1;
	logic        in_range_s1;
	logic [7:0]  code_s1;
	logic [7:0]  rdata_s1;
	logic [15:0] origin_x_s1;
	logic [15:0] origin_y_s1;
	logic        first_s1;
	logic        last_s1;
	logic        accept;
	logic        in_range;

	assign in_range = ({1'b0, char_code} < 9'(GLYPH_COUNT));
	assign in_ready = !valid_s1 || push_ready;
	assign accept   = in_valid && in_ready;

	// Loads and reads both happen at the accept edge, so an in-range load is always
	// in the table before any later item reads it.
	always_ff @(posedge clk) begin
		if (accept && !kind && in_range) begin
			width_mem[char_code[ADDR_W-1:0]] <= glyph_width;
		end
		if (accept && kind && in_range) begin
			rdata_s1 <= width_mem[char_code[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind;
			in_range_s1 <= in_range;
			code_s1     <= char_code;
			origin_x_s1 <= origin_x;
			origin_y_s1 <= origin_y;
			first_s1    <= first;
			last_s1     <= last;
		end
	end

	always_comb begin
		push_item.code     = code_s1;
		push_item.width    = in_range_s1 ? rdata_s1 : 8'd0;
		push_item.origin_x = origin_x_s1;
		push_item.origin_y = origin_y_s1;
		push_item.first    = first_s1;
		push_item.last     = last_s1;
		if (!kind_s1) begin
			push_item.op = OP_LOAD;
		end else if (!font_ready) begin
			push_item.op = OP_NOT_READY;
		end else if (code_s1 == CODE_SPACE) begin
			push_item.op = OP_SPACE;
		end else if (code_s1 == CODE_NEWLINE) begin
			push_item.op = OP_NEWLINE;
		end else begin
			push_item.op = OP_GLYPH;
		end
	end

	assign push_valid = valid_s1;

endmodule

`default_nettype wire

// ----- src/bftl_queue.sv -----
`default_nettype none

module bftl_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire bftl_pkg::bftl_item_t push_item,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output bftl_pkg::bftl_item_t    pop_item
);
	import bftl_pkg::*;

	bftl_item_t             slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;

	assign pop_valid  = (count_q != '0);
	assign pop        = pop_valid && pop_ready;
	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH)) || pop_ready;
	assign push       = push_valid && push_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/bftl_back.sv -----
`default_nettype none

module bftl_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pop_valid,
	output logic                    pop_ready,
	input  wire bftl_pkg::bftl_item_t pop_item,
	input  wire logic [7:0]         space_advance,
	input  wire logic [7:0]         line_advance,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    draw,
	output logic [7:0]              glyph_code,
	output logic [15:0]             pen_x,
	output logic [15:0]             pen_y,
	output logic [15:0]             text_width,
	output logic [15:0]             text_height,
	output logic                    done_res,
	output logic                    not_ready
);
	import bftl_pkg::*;

	function automatic logic [15:0] sat_add_s16(input logic [15:0] a, input logic [8:0] b);
		logic [16:0] s;
		s = {a[15], a} + {8'd0, b};
		// A non-negative step can only run past the top of the range.
		return (!s[16] && s[15]) ? 16'h7FFF : s[15:0];
	endfunction

	function automatic logic [15:0] sat_add_u16(input logic [15:0] a, input logic [8:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {8'd0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	logic [15:0] pen_x_q, pen_y_q, line_start_x_q;
	logic [15:0] line_width_q, widest_line_q, height_sum_q;
	logic [15:0] px, py, lsx, lw, wl, hs;
	logic [15:0] px_n, py_n, lw_n, wl_n, hs_n;
	logic [8:0]  glyph_step;
	logic        pop;
	logic        text_item;

	logic        r_draw, r_done, r_not_ready;
	logic [7:0]  r_code;
	logic [15:0] r_pen_x, r_pen_y, r_width, r_height;

	assign pop_ready  = !out_valid || out_ready;
	assign pop        = pop_valid && pop_ready;
	assign glyph_step = {1'b0, pop_item.width} + 9'd1;
	assign text_item  = (pop_item.op == OP_SPACE) || (pop_item.op == OP_NEWLINE)
		|| (pop_item.op == OP_GLYPH);

	always_comb begin
		// Start of a string puts the pen at the origin and clears the measures.
		if (text_item && pop_item.first) begin
			px  = pop_item.origin_x;
			py  = pop_item.origin_y;
			lsx = pop_item.origin_x;
			lw  = '0;
			wl  = '0;
			hs  = '0;
		end else begin
			px  = pen_x_q;
			py  = pen_y_q;
			lsx = line_start_x_q;
			lw  = line_width_q;
			wl  = widest_line_q;
			hs  = height_sum_q;
		end
		px_n        = px;
		py_n        = py;
		lw_n        = lw;
		wl_n        = wl;
		hs_n        = hs;
		r_draw      = 1'b0;
		r_code      = '0;
		r_pen_x     = '0;
		r_pen_y     = '0;
		r_not_ready = 1'b0;
		unique case (pop_item.op)
			OP_LOAD: begin
			end
			OP_NOT_READY: begin
				r_not_ready = 1'b1;
			end
			OP_SPACE: begin
				px_n = sat_add_s16(px, {1'b0, space_advance});
				lw_n = sat_add_u16(lw, {1'b0, space_advance});
			end
			OP_NEWLINE: begin
				py_n = sat_add_s16(py, {1'b0, line_advance});
				px_n = lsx;
				hs_n = sat_add_u16(hs, {1'b0, line_advance});
				wl_n = (lw > wl) ? lw : wl;
				lw_n = '0;
			end
			OP_GLYPH: begin
				r_draw  = 1'b1;
				r_code  = pop_item.code;
				r_pen_x = px;
				r_pen_y = py;
				px_n    = sat_add_s16(px, glyph_step);
				lw_n    = sat_add_u16(lw, glyph_step);
			end
			default: begin
			end
		endcase
		r_done   = text_item && pop_item.last;
		r_width  = r_done ? ((lw_n > wl_n) ? lw_n : wl_n) : 16'd0;
		r_height = r_done ? hs_n : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q        <= '0;
			pen_y_q        <= '0;
			line_start_x_q <= '0;
			line_width_q   <= '0;
			widest_line_q  <= '0;
			height_sum_q   <= '0;
		end else if (pop && text_item) begin
			pen_x_q        <= px_n;
			pen_y_q        <= py_n;
			line_start_x_q <= lsx;
			line_width_q   <= lw_n;
			widest_line_q  <= wl_n;
			height_sum_q   <= hs_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pop) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			draw        <= r_draw;
			glyph_code  <= r_code;
			pen_x       <= r_pen_x;
			pen_y       <= r_pen_y;
			text_width  <= r_width;
			text_height <= r_height;
			done_res    <= r_done;
			not_ready   <= r_not_ready;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bftl_pkg::*;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TEXT = 1'b1;

	// Glyphs with fixed widths so that the directed strings are predictable.
	localparam logic [7:0] GLYPH_ZERO_W = 8'h00;
	localparam logic [7:0] GLYPH_ONE_W  = 8'h80;
	localparam logic [7:0] GLYPH_FIVE_W = 8'h41;
	localparam logic [7:0] GLYPH_WIDE   = 8'h7F;
	localparam logic [7:0] GLYPH_TOP    = 8'hFF;

	localparam realtime RUN_LIMIT = 10ms;

	typedef struct {
		logic               kind;
		logic [7:0]         code;
		logic [7:0]         gw;
		logic signed [15:0] ox;
		logic signed [15:0] oy;
		logic               first;
		logic               last;
	} layout_item_t;

	typedef struct {
		logic        draw;
		logic [7:0]  code;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] tw;
		logic [15:0] th;
		logic        done;
		logic        nrdy;
	} placement_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	bitmap_font_text_layout_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Layout state mirrored from the block.
	logic [7:0]  glyph_widths [256];
	int          pen_x_q;
	int          pen_y_q;
	int          line_origin_x;
	int unsigned cur_line_w;
	int unsigned widest_w;
	int unsigned height_acc;
	logic [7:0]  space_step;
	logic [7:0]  line_step;
	logic        font_ok;

	placement_t  pending_placements [$];
	bit          idle_on;
	int          errors;
	int          items_sent;
	int          results_seen;
	int          glyphs_placed;
	int          strings_closed;
	int          refused_items;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("tb: failure");
		$finish;
	end

	function automatic int clamp_s16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int unsigned clamp_u16(int unsigned v);
		return (v > 65535) ? 65535 : v;
	endfunction

	function automatic placement_t predict_layout(layout_item_t it);
		placement_t  r;
		int unsigned w;
		r = '{default: '0};
		if (it.kind == KIND_LOAD) begin
			glyph_widths[it.code] = it.gw;
			return r;
		end
		if (!font_ok) begin
			r.nrdy = 1'b1;
			return r;
		end
		if (it.first) begin
			pen_x_q       = int'(it.ox);
			pen_y_q       = int'(it.oy);
			line_origin_x = int'(it.ox);
			cur_line_w    = 0;
			widest_w      = 0;
			height_acc    = 0;
		end
		if (it.code == CODE_SPACE) begin
			pen_x_q    = clamp_s16(pen_x_q + int'(space_step));
			cur_line_w = clamp_u16(cur_line_w + 32'(space_step));
		end else if (it.code == CODE_NEWLINE) begin
			pen_y_q    = clamp_s16(pen_y_q + int'(line_step));
			pen_x_q    = line_origin_x;
			height_acc = clamp_u16(height_acc + 32'(line_step));
			if (cur_line_w > widest_w)
				widest_w = cur_line_w;
			cur_line_w = 0;
		end else begin
			w      = 32'(glyph_widths[it.code]);
			r.draw = 1'b1;
			r.code = it.code;
			r.px   = pen_x_q[15:0];
			r.py   = pen_y_q[15:0];
			pen_x_q    = clamp_s16(pen_x_q + int'(w) + 1);
			cur_line_w = clamp_u16(cur_line_w + w + 1);
		end
		if (it.last) begin
			r.tw   = (cur_line_w > widest_w) ? cur_line_w[15:0] : widest_w[15:0];
			r.th   = height_acc[15:0];
			r.done = 1'b1;
		end
		return r;
	endfunction

	function automatic layout_item_t load_entry(logic [7:0] code, logic [7:0] width);
		layout_item_t it;
		it.kind  = KIND_LOAD;
		it.code  = code;
		it.gw    = width;
		// Fields that a load ignores still carry random bits.
		it.ox    = 16'($urandom());
		it.oy    = 16'($urandom());
		it.first = 1'($urandom_range(0, 1));
		it.last  = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic layout_item_t text_char(logic [7:0] code, logic signed [15:0] ox,
			logic signed [15:0] oy, logic first, logic last);
		layout_item_t it;
		it.kind  = KIND_TEXT;
		it.code  = code;
		it.gw    = 8'($urandom());
		it.ox    = ox;
		it.oy    = oy;
		it.first = first;
		it.last  = last;
		return it;
	endfunction

	function automatic logic signed [15:0] random_coord();
		case ($urandom_range(0, 11))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic layout_item_t random_char(logic first, logic last);
		logic [7:0] code;
		case ($urandom_range(0, 9))
			0, 1: code = CODE_SPACE;
			2, 3: code = CODE_NEWLINE;
			default: code = 8'($urandom_range(0, 255));
		endcase
		return text_char(code, random_coord(), random_coord(), first, last);
	endfunction

	// Drives one item at a falling edge and holds it until it is taken.
	task automatic send_item(layout_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tlast  <= it.last;
		s_tdata  <= {7'b0, it.first, it.oy, it.ox, it.gw, it.code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_placements.push_back(predict_layout(it));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_placements.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Writes all three registers on consecutive cycles once the block is idle.
	task automatic configure(logic [7:0] space, logic [7:0] line, logic ready);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SPACE_ADVANCE;
		cfg_wdata <= space;
		@(negedge clk);
		cfg_index <= CFG_LINE_ADVANCE;
		cfg_wdata <= line;
		@(negedge clk);
		cfg_index <= CFG_FONT_READY;
		cfg_wdata <= {7'b0, ready};
		@(negedge clk);
		cfg_we     <= 1'b0;
		space_step = space;
		line_step  = line;
		font_ok    = ready;
		@(negedge clk);
	endtask

	function automatic bit field_differs(string name, int unsigned exp, int unsigned got);
		if (exp != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		placement_t exp;
		bit         bad;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_placements.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got tdata %0h",
					$realtime, m_tdata);
				errors++;
			end else begin
				exp = pending_placements.pop_front();
				bad = 1'b0;
				bad |= field_differs("draw", 32'(exp.draw), 32'(m_tuser[0]));
				bad |= field_differs("glyph_code", 32'(exp.code), 32'(m_tdata[7:0]));
				bad |= field_differs("pen_x", 32'(exp.px), 32'(m_tdata[23:8]));
				bad |= field_differs("pen_y", 32'(exp.py), 32'(m_tdata[39:24]));
				bad |= field_differs("text_width", 32'(exp.tw), 32'(m_tdata[55:40]));
				bad |= field_differs("text_height", 32'(exp.th), 32'(m_tdata[71:56]));
				bad |= field_differs("done", 32'(exp.done), 32'(m_tlast));
				bad |= field_differs("not_ready", 32'(exp.nrdy), 32'(m_tuser[1]));
				if (bad)
					errors++;
				glyphs_placed  += int'(exp.draw);
				strings_closed += int'(exp.done);
				refused_items  += int'(exp.nrdy);
			end
		end
	end

	// Result side: random stall bursts while idling is enabled.
	initial begin
		m_tready = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end
		end
	end

	task automatic test_font_load();
		logic [7:0] w;
		for (int c = 0; c < 256; c++) begin
			case (8'(c))
				GLYPH_ZERO_W: w = 8'd0;
				GLYPH_ONE_W:  w = 8'd1;
				GLYPH_FIVE_W: w = 8'd5;
				GLYPH_WIDE, GLYPH_TOP: w = 8'd255;
				default: w = 8'($urandom());
			endcase
			send_item(load_entry(8'(c), w));
		end
		drain_results();
	endtask

	// A string is interrupted by a not-ready spell; its pen must survive it.
	task automatic test_font_not_ready();
		configure(8'd4, 8'd12, 1'b1);
		send_item(text_char(GLYPH_FIVE_W, 16'sd100, 16'sd200, 1'b1, 1'b0));
		send_item(text_char(CODE_SPACE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		configure(8'd4, 8'd12, 1'b0);
		send_item(text_char(GLYPH_TOP, -16'sd5, -16'sd5, 1'b1, 1'b0));
		send_item(text_char(CODE_NEWLINE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(CODE_SPACE, 16'sd0, 16'sd0, 1'b1, 1'b1));
		send_item(load_entry(GLYPH_ONE_W, 8'd1));
		configure(8'd4, 8'd12, 1'b1);
		send_item(text_char(GLYPH_ONE_W, 16'sd0, 16'sd0, 1'b0, 1'b1));
		drain_results();
	endtask

	task automatic test_directed_layout();
		configure(8'd3, 8'd10, 1'b1);
		send_item(text_char(GLYPH_FIVE_W, 16'sh8000, 16'sh8000, 1'b1, 1'b0));
		send_item(text_char(CODE_SPACE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(GLYPH_ZERO_W, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(CODE_NEWLINE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(GLYPH_TOP, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(GLYPH_ONE_W, 16'sd0, 16'sd0, 1'b0, 1'b1));
		// Single-character string at the far corner.
		send_item(text_char(GLYPH_WIDE, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1));
		// The pen runs into the right edge and stays there.
		send_item(text_char(GLYPH_TOP, 16'sd32500, 16'sd0, 1'b1, 1'b0));
		send_item(text_char(GLYPH_TOP, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(GLYPH_FIVE_W, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(CODE_NEWLINE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(CODE_NEWLINE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(CODE_SPACE, 16'sd0, 16'sd0, 1'b0, 1'b1));
		configure(8'd255, 8'd255, 1'b1);
		send_item(text_char(CODE_NEWLINE, -16'sd1, 16'sd32600, 1'b1, 1'b0));
		send_item(text_char(CODE_NEWLINE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(GLYPH_TOP, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(CODE_SPACE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(CODE_SPACE, 16'sd0, 16'sd0, 1'b0, 1'b1));
		configure(8'd0, 8'd0, 1'b1);
		send_item(text_char(CODE_SPACE, 16'sd7, 16'sd9, 1'b1, 1'b0));
		send_item(text_char(CODE_NEWLINE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(GLYPH_ZERO_W, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(CODE_NEWLINE, 16'sd0, 16'sd0, 1'b0, 1'b1));
		drain_results();
	endtask

	// One long string that drives the line width and the height to their ceilings.
	task automatic test_measure_saturation();
		configure(8'd255, 8'd255, 1'b1);
		send_item(text_char(GLYPH_TOP, 16'sh8000, 16'sh8000, 1'b1, 1'b0));
		for (int i = 0; i < 259; i++)
			send_item(text_char((i % 7 == 3) ? CODE_SPACE : GLYPH_WIDE,
				16'sd0, 16'sd0, 1'b0, 1'b0));
		for (int i = 0; i < 258; i++)
			send_item(text_char(CODE_NEWLINE, 16'sd0, 16'sd0, 1'b0, 1'b0));
		send_item(text_char(GLYPH_FIVE_W, 16'sd0, 16'sd0, 1'b0, 1'b1));
		drain_results();
	endtask

	// Mostly whole strings with random content, some loads and broken framing.
	task automatic run_random_strings(int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 19))
				0, 1: begin
					send_item(load_entry(8'($urandom()), 8'($urandom())));
					sent++;
				end
				2: begin
					send_item(random_char(1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))));
					sent++;
				end
				default: begin
					len = $urandom_range(1, 12);
					for (int i = 0; i < len; i++)
						send_item(random_char(i == 0, i == len - 1));
					sent += len;
				end
			endcase
		end
	endtask

	function automatic logic [7:0] random_step();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic test_random_layout();
		for (int phase = 0; phase < 6; phase++) begin
			configure(random_step(), random_step(), (phase == 2) ? 1'b0 : 1'b1);
			run_random_strings(15);
		end
	endtask

	task automatic test_back_to_back();
		configure(random_step(), random_step(), 1'b1);
		drain_results();
		idle_on = 1'b0;
		run_random_strings(45);
		drain_results();
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_on   = 1'b1;
		errors    = 0;
		items_sent     = 0;
		results_seen   = 0;
		glyphs_placed  = 0;
		strings_closed = 0;
		refused_items  = 0;
		pen_x_q       = 0;
		pen_y_q       = 0;
		line_origin_x = 0;
		cur_line_w    = 0;
		widest_w      = 0;
		height_acc    = 0;
		space_step    = '0;
		line_step     = '0;
		font_ok       = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_font_load();
		test_font_not_ready();
		test_directed_layout();
		test_measure_saturation();
		test_random_layout();
		test_back_to_back();

		repeat (10) @(negedge clk);
		$display("tb: %0d items in, %0d results checked, %0d glyphs placed, %0d strings closed",
			items_sent, results_seen, glyphs_placed, strings_closed);
		$display("tb: %0d text items refused while the font was not ready, %0d errors",
			refused_items, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
